// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker of the class queue.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define DRR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define DRR_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/drr_pkg.sv -----
// Types, codes and reset constants of the DRR class queue.
// No dependencies; used by every other file of the block but drr_ram and the macros.
package drr_pkg;

    // Default descriptor store depth
    localparam int QUEUE_DEPTH_DEF = 1024;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int LEN_W   = 16;
    localparam int TAG_W   = 16;
    localparam int AMT_W   = 32;
    localparam int STAT_W  = 3;
    localparam int BYTES_W = 26;
    localparam int PKTS_W  = 11;
    localparam int DESC_W  = LEN_W + TAG_W;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_ENQ     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DRR_DEQ = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ADD_DEF = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET_DEF = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_LIMIT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DEFICIT = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_BYTE_MODE    = 2'd0;
    localparam logic [1:0] REG_BYTE_LIMIT   = 2'd1;
    localparam logic [1:0] REG_PACKET_LIMIT = 2'd2;

    // Register reset values
    localparam logic [BYTES_W-1:0] BYTE_LIMIT_RST   = 26'd1024000;
    localparam logic [PKTS_W-1:0]  PACKET_LIMIT_RST = 11'd1000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [LEN_W-1:0]  pkt_len;
        logic [TAG_W-1:0]  pkt_tag;
        logic [AMT_W-1:0]  amount;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LEN_W-1:0]   out_len;
        logic [TAG_W-1:0]   out_tag;
        logic [BYTES_W-1:0] byte_count;
        logic [PKTS_W-1:0]  packet_count;
        logic [AMT_W-1:0]   deficit_now;
    } t_result;

    typedef struct packed {
        logic               byte_mode;
        logic [BYTES_W-1:0] byte_limit;
        logic [PKTS_W-1:0]  packet_limit;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/drr_if.sv -----
// Valid/ready channel interfaces for input and result words.
// Depends on drr_pkg for the payload types.
interface drr_item_if;
    logic          valid;
    logic          ready;
    drr_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface drr_res_if;
    logic            valid;
    logic            ready;
    drr_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/drr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/drr_datapath.sv -----
// Datapath: descriptor RAM, pointers, counters, deficit and result register.
// Depends on drr_pkg and drr_ram; driven by drr_ctrl commands.
module drr_datapath #(
    parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  drr_pkg::t_item    i_item,
    input  drr_pkg::t_cfg     i_cfg,
    input  drr_pkg::t_dp_cmd  i_cmd,
    output drr_pkg::t_dp_sts  o_sts,
    output drr_pkg::t_result  o_res,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    import drr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    t_item              r_item;
    t_result            r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [PKTS_W-1:0]  r_pkts, n_pkts;
    logic [AMT_W-1:0]   r_def, n_def;

    logic               ram_we;
    logic [DESC_W-1:0]  ram_rdata;
    logic [LEN_W-1:0]   head_len;
    logic [TAG_W-1:0]   head_tag;
    logic               fits;
    logic [BYTES_W:0]   bytes_sum;
    logic [PKTS_W:0]    pkts_sum;
    logic [AMT_W:0]     def_sum;
    logic [BYTES_W-1:0] len_ext;

    // Descriptor store; read port always looks at the head
    drr_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({r_item.pkt_tag, r_item.pkt_len}),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign head_len = ram_rdata[LEN_W-1:0];
    assign head_tag = ram_rdata[DESC_W-1:LEN_W];
    assign len_ext  = BYTES_W'(r_item.pkt_len);

    // Admission check against the limit of the active mode
    always_comb begin
        bytes_sum = {1'b0, r_bytes} + {1'b0, len_ext};
        pkts_sum  = {1'b0, r_pkts} + (PKTS_W + 1)'(1);
        def_sum   = {1'b0, r_def} + {1'b0, r_item.amount};
        if (i_cfg.byte_mode) begin
            fits = bytes_sum <= {1'b0, i_cfg.byte_limit};
        end else begin
            fits = pkts_sum <= {1'b0, i_cfg.packet_limit};
        end
    end

    // Next state and result of the held item
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        n_bytes = r_bytes;
        n_pkts  = r_pkts;
        n_def   = r_def;
        ram_we  = 1'b0;
        n_res   = '0;
        n_res.status = ST_OK;

        unique case (r_item.func)
            FN_ENQ: begin
                if (!fits) begin
                    n_res.status = ST_LIMIT;
                end else if (r_occ == FULL_OCC) begin
                    n_res.status = ST_FULL;
                end else begin
                    ram_we = i_cmd.commit;
                    n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + PTR_W'(1);
                    n_occ  = r_occ + OCC_W'(1);
                    if (i_cfg.byte_mode) begin
                        n_bytes = bytes_sum[BYTES_W-1:0];
                    end else begin
                        n_pkts = pkts_sum[PKTS_W-1:0];
                    end
                end
            end
            FN_DEQ, FN_DRR_DEQ: begin
                if (r_occ == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.out_len = head_len;
                    n_res.out_tag = head_tag;
                    if (r_item.func == FN_DRR_DEQ && AMT_W'(head_len) > r_def) begin
                        n_res.status = ST_DEFICIT;
                    end else begin
                        if (r_item.func == FN_DRR_DEQ) begin
                            n_def = r_def - AMT_W'(head_len);
                        end
                        n_head = (r_head == LAST_IDX) ? '0 : r_head + PTR_W'(1);
                        n_occ  = r_occ - OCC_W'(1);
                        if (i_cfg.byte_mode) begin
                            n_bytes = (r_bytes >= BYTES_W'(head_len)) ?
                                      r_bytes - BYTES_W'(head_len) : '0;
                        end else if (r_pkts != '0) begin
                            n_pkts = r_pkts - PKTS_W'(1);
                        end
                    end
                end
            end
            FN_ADD_DEF: begin
                n_def = def_sum[AMT_W] ? '1 : def_sum[AMT_W-1:0];
            end
            FN_SET_DEF: begin
                n_def = r_item.amount;
            end
            default: begin
            end
        endcase

        n_res.byte_count   = n_bytes;
        n_res.packet_count = n_pkts;
        n_res.deficit_now  = n_def;
    end

    // Output register: free when empty or being taken this cycle
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    always_comb begin
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_bytes     <= '0;
            r_pkts      <= '0;
            r_def       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.commit) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_occ   <= n_occ;
                r_bytes <= n_bytes;
                r_pkts  <= n_pkts;
                r_def   <= n_def;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    assign o_res       = r_res;
    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/drr_ctrl.sv -----
// Controller: takes one word, waits for the head read, commits the result.
// Depends on drr_pkg for the command and status structs.
module drr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  drr_pkg::t_dp_sts i_sts,
    output drr_pkg::t_dp_cmd o_cmd
);
    import drr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Advance on accept, return once the result register takes the result
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/drr_class_queue.sv -----
// A word accepted in S_IDLE is loaded into the item register; in S_EXEC its
// result is committed to the result register once that register is free.
// One word is in work at a time: the next word is accepted only after the
// result of the last is committed. S_EXEC waits on the registered read of
// the descriptor RAM at the head; a result word not taken holds it in S_EXEC.
// Reset (synchronous, active low): pointers, counters and deficit to zero,
// limits to their defaults, no result pending. Descriptor RAM is not cleared.
// Top level; depends on drr_pkg, drr_if, drr_ctrl, drr_datapath, drr_ram.
module drr_class_queue #(
    parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    drr_item_if.sink                    i_item,
    drr_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [drr_pkg::APB_AW-1:0]  paddr,
    input  logic [drr_pkg::APB_DW-1:0]  pwdata,
    output logic [drr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import drr_pkg::*;

    t_cfg       r_cfg;
    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic       cfg_we;
    logic [1:0] reg_idx;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_mode    <= 1'b0;
            r_cfg.byte_limit   <= BYTE_LIMIT_RST;
            r_cfg.packet_limit <= PACKET_LIMIT_RST;
        end else if (cfg_we) begin
            if (reg_idx == REG_BYTE_MODE) begin
                r_cfg.byte_mode <= pwdata[0];
            end
            if (reg_idx == REG_BYTE_LIMIT) begin
                r_cfg.byte_limit <= pwdata[BYTES_W-1:0];
            end
            if (reg_idx == REG_PACKET_LIMIT) begin
                r_cfg.packet_limit <= pwdata[PKTS_W-1:0];
            end
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_BYTE_MODE:    prdata = APB_DW'(r_cfg.byte_mode);
            REG_BYTE_LIMIT:   prdata = APB_DW'(r_cfg.byte_limit);
            REG_PACKET_LIMIT: prdata = APB_DW'(r_cfg.packet_limit);
            default:          prdata = '0;
        endcase
    end

    drr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    drr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item.data),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res.data),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready)
    );

endmodule

// ----- hw/rtl/drr_checker.sv -----
// Port-level checks of the class queue, bound to drr_class_queue.
// Depends on drr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input drr_pkg::t_result i_out_data
);
    import drr_pkg::*;

    // A stalled result word stays and holds
    `DRR_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "result word dropped or changed while stalled")

    // One word in work at a time
    `DRR_ASSERT(a_one_in_work, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "second word accepted while one is in work")

    // Empty dequeue reports no descriptor
    `DRR_ASSERT(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_out_data.status == ST_EMPTY |-> i_out_data.out_len == '0 && i_out_data.out_tag == '0, "empty dequeue shows a descriptor")

    // Reset drops any pending result and reopens the input
    `DRR_ASSERT_NORST(a_reset_clear, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready, "reset left a result pending or input closed")

endmodule

bind drr_class_queue drr_checker u_drr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
